[sv/dnc_pkg.sv]
// dnc_pkg: shared types and constants of the dns name compressor
// used by dnc_front, dnc_back and dns_name_compressor_core; no dependencies
package dnc_pkg;

    localparam int MAX_TARGETS      = 256;
    localparam int NAME_STORE_BYTES = 4096;

    localparam int TIW = $clog2(MAX_TARGETS);       // table index bits
    localparam int TCW = TIW + 1;                   // table count bits
    localparam int SAW = $clog2(NAME_STORE_BYTES);  // name store address bits
    localparam int SFW = SAW + 1;                   // store fill bits
    localparam int NBW = 2;                         // name buffer bank bits
    localparam int BAW = NBW + 8;                   // name buffer address bits

    localparam logic [7:0]  NAME_MAX = 8'd255;
    localparam logic [15:0] QNAME_AT = 16'd12;
    localparam logic [16:0] PTR_MAX  = 17'd16383;
    localparam logic [7:0]  MIN_LEN  = 8'd2;
    localparam logic        REQ_QNAME = 1'b0;
    localparam logic        REQ_STORE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  name_byte;
        logic        byte_last;
        logic [15:0] name_offset;
        logic        add_targets;
    } t_in;

    typedef struct packed {
        logic        compressed;
        logic [7:0]  prefix_len;
        logic [13:0] pointer_offset;
        logic [7:0]  wr_len;
    } t_out;

    // one complete name handed from front to back
    typedef struct packed {
        logic [NBW-1:0] bank;
        logic           kind;
        logic [15:0]    base;
        logic           add;
        logic [7:0]     len;
    } t_job;

    // name buffer write port
    typedef struct packed {
        logic           en;
        logic [BAW-1:0] addr;
        logic [7:0]     data;
    } t_bwr;

    // one compression target
    typedef struct packed {
        logic [SAW-1:0] addr;
        logic [7:0]     len;
        logic [13:0]    off;
    } t_tgt;

    typedef enum logic [3:0] {
        B_IDLE, B_RDT, B_LAT, B_CHK, B_SHA, B_SHB, B_PUT, B_NPA,
        B_NPB, B_CMA, B_CMB, B_NXT, B_TAIL, B_KPA, B_KPB, B_OUT
    } t_bst;

endpackage

[sv/dnc_front.sv]
// dnc_front: accepts name bytes, fills the banked name buffer, queues whole names
// depends on dnc_pkg
module dnc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dnc_pkg::t_in  i_in_data,
    output dnc_pkg::t_bwr o_bwr,
    output logic          o_job_valid,
    output dnc_pkg::t_job o_job,
    input  logic          i_job_pop
);
    import dnc_pkg::*;

    logic [NBW-1:0] r_wbank, n_wbank;
    logic [7:0]     r_cnt, n_cnt;
    t_job           r_q [2];
    logic           r_rd, n_rd, r_wr, n_wr;
    logic [1:0]     r_qn, n_qn;
    logic           acc, push;
    logic [7:0]     len_now;
    t_job           job_new;

    assign o_in_ready  = (r_qn != 2'd2);
    assign acc         = i_in_valid && o_in_ready;
    assign push        = acc && i_in_data.byte_last;
    assign o_job_valid = (r_qn != 2'd0);
    assign o_job       = r_q[r_rd];

    // byte lands at the running count of the current bank
    assign len_now = (r_cnt == NAME_MAX) ? NAME_MAX : r_cnt + 8'd1;
    always_comb begin
        o_bwr.en   = acc && (r_cnt != NAME_MAX);
        o_bwr.addr = {r_wbank, r_cnt};
        o_bwr.data = i_in_data.name_byte;
        job_new.bank = r_wbank;
        job_new.kind = i_in_data.req_type;
        job_new.base = i_in_data.name_offset;
        job_new.add  = i_in_data.add_targets;
        job_new.len  = len_now;
    end

    // counters and queue pointers
    always_comb begin
        n_cnt   = r_cnt;
        n_wbank = r_wbank;
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_qn    = r_qn;
        if (acc) begin
            n_cnt = len_now;
        end
        if (push) begin
            n_cnt   = 8'd0;
            n_wbank = r_wbank + NBW'(1);
            n_wr    = ~r_wr;
        end
        if (i_job_pop) begin
            n_rd = ~r_rd;
        end
        n_qn = r_qn + {1'b0, push} - {1'b0, i_job_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 8'd0;
            r_wbank <= '0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_qn    <= 2'd0;
        end else begin
            r_cnt   <= n_cnt;
            r_wbank <= n_wbank;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_qn    <= n_qn;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job_new;
        end
    end

    a_qn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn <= 2'd2) else $error("job queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_pop |-> r_qn != 2'd0) else $error("pop from empty job queue");
    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_cnt == 8'd0) else $error("byte count not cleared after name");

endmodule

[sv/dnc_back.sv]
// dnc_back: target table walk, suffix compare, sorted insert and name store copy
// depends on dnc_pkg; holds the name buffer, target table and name store memories
module dnc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dnc_pkg::t_bwr i_bwr,
    input  logic          i_job_valid,
    input  dnc_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output dnc_pkg::t_out o_res
);
    import dnc_pkg::*;

    // memories
    logic [7:0] m_buf [1 << BAW];
    logic [7:0] m_store [NAME_STORE_BYTES];
    t_tgt       m_tab [MAX_TARGETS];

    logic [BAW-1:0] br_a;
    logic [7:0]     r_brd;
    logic [SAW-1:0] sr_a, sw_a;
    logic           sw_en;
    logic [7:0]     r_srd;
    logic [TIW-1:0] tr_a, tw_a;
    logic           tw_en;
    t_tgt           tw_d, r_trd;

    // sequencer state
    t_bst           r_st, n_st;
    logic           r_kind, n_kind;
    logic [15:0]    r_base, n_base;
    logic [7:0]     r_len, n_len;
    logic [NBW-1:0] r_bank, n_bank;
    logic [7:0]     r_p, n_p;
    logic [7:0]     r_k, n_k;
    logic [TCW-1:0] r_i, n_i, r_j, n_j, r_cnt, n_cnt;
    logic [SFW-1:0] r_fill, n_fill;
    logic           r_make, n_make, r_added, n_added, r_intail, n_intail;
    t_tgt           r_t, n_t;
    t_out           r_res, n_res;

    logic [7:0]     rem;
    logic [16:0]    ptr_at_p;
    logic [SFW:0]   free_bytes;
    logic [8:0]     jump;
    logic [7:0]     np;
    logic [16:0]    ptr_at_np;
    logic           room;

    always_ff @(posedge i_clk) begin
        if (i_bwr.en) begin
            m_buf[i_bwr.addr] <= i_bwr.data;
        end
        r_brd <= m_buf[br_a];
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) begin
            m_store[sw_a] <= r_brd;
        end
        r_srd <= m_store[sr_a];
    end

    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            m_tab[tw_a] <= tw_d;
        end
        r_trd <= m_tab[tr_a];
    end

    // shared arithmetic
    assign rem        = r_len - r_p;
    assign ptr_at_p   = {1'b0, r_base} + {9'd0, r_p};
    assign free_bytes = SFW'(NAME_STORE_BYTES) - {1'b0, r_fill};
    assign jump       = {1'b0, r_brd} + 9'd1;
    assign np         = (r_p >= r_len) ? r_len :
                        (jump <= {1'b0, rem}) ? r_p + jump[7:0] : r_len;
    assign ptr_at_np  = {1'b0, r_base} + {9'd0, np};
    assign room       = r_cnt < TCW'(MAX_TARGETS);
    assign o_res      = r_res;

    // next state and memory controls
    always_comb begin
        n_st = r_st; n_kind = r_kind; n_base = r_base; n_len = r_len;
        n_bank = r_bank; n_p = r_p; n_k = r_k; n_i = r_i; n_j = r_j;
        n_cnt = r_cnt; n_fill = r_fill; n_make = r_make; n_added = r_added;
        n_intail = r_intail; n_t = r_t; n_res = r_res;
        br_a = {r_bank, r_p};
        sr_a = r_t.addr + {{(SAW-8){1'b0}}, r_k};
        sw_en = 1'b0;
        sw_a = r_fill[SAW-1:0] + {{(SAW-8){1'b0}}, r_k};
        tr_a = r_i[TIW-1:0];
        tw_en = 1'b0;
        tw_a = r_i[TIW-1:0];
        tw_d.addr = r_fill[SAW-1:0] + {{(SAW-8){1'b0}}, r_p};
        tw_d.len  = rem;
        tw_d.off  = ptr_at_p[13:0];
        o_job_pop = 1'b0;
        o_res_valid = 1'b0;
        case (r_st)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_kind  = i_job.kind;
                    n_len   = i_job.len;
                    n_bank  = i_job.bank;
                    n_p     = 8'd0;
                    n_i     = '0;
                    n_added = 1'b0;
                    if (i_job.kind == REQ_QNAME) begin
                        n_cnt    = '0;
                        n_fill   = '0;
                        n_make   = 1'b1;
                        n_base   = QNAME_AT;
                        n_intail = 1'b1;
                        n_st     = B_TAIL;
                    end else begin
                        n_base   = i_job.base;
                        n_make   = i_job.add && ({1'b0, i_job.base} <= PTR_MAX) &&
                                   ({{(SFW-7){1'b0}}, i_job.len} <= free_bytes);
                        n_intail = (r_cnt == '0);
                        n_st     = (r_cnt == '0) ? B_TAIL : B_RDT;
                    end
                end
            end
            B_RDT: begin
                n_st = B_LAT;
            end
            B_LAT: begin
                n_t  = r_trd;
                n_st = B_CHK;
            end
            // shorter target: insert own suffix before it, then step a label
            B_CHK: begin
                if (r_t.len < rem) begin
                    if (r_make && room) begin
                        n_j  = r_cnt;
                        n_st = B_SHA;
                    end else begin
                        n_st = B_NPA;
                    end
                end else if (r_t.len == rem) begin
                    n_k  = 8'd0;
                    n_st = B_CMA;
                end else begin
                    n_st = B_NXT;
                end
            end
            // shift entries up by one, from the top down
            B_SHA: begin
                tr_a = r_j[TIW-1:0] - TIW'(1);
                n_st = (r_j == r_i) ? B_PUT : B_SHB;
            end
            B_SHB: begin
                tw_en = 1'b1;
                tw_a  = r_j[TIW-1:0];
                tw_d  = r_trd;
                n_j   = r_j - TCW'(1);
                n_st  = B_SHA;
            end
            B_PUT: begin
                tw_en   = 1'b1;
                tw_a    = r_intail ? r_cnt[TIW-1:0] : r_i[TIW-1:0];
                n_cnt   = r_cnt + TCW'(1);
                n_added = 1'b1;
                if (!r_intail) begin
                    n_i = r_i + TCW'(1);
                end
                n_st = B_NPA;
            end
            B_NPA: begin
                n_st = B_NPB;
            end
            B_NPB: begin
                n_p = np;
                if (ptr_at_np > PTR_MAX) begin
                    n_make = 1'b0;
                end
                n_st = r_intail ? B_TAIL : B_CHK;
            end
            // byte compare of suffix against stored target
            B_CMA: begin
                br_a = {r_bank, r_p + r_k};
                n_st = B_CMB;
            end
            B_CMB: begin
                if (r_srd != r_brd) begin
                    n_st = B_NXT;
                end else if ({1'b0, r_k} + 9'd1 == {1'b0, rem}) begin
                    n_res.compressed     = 1'b1;
                    n_res.prefix_len     = r_p;
                    n_res.pointer_offset = r_t.off;
                    n_res.wr_len         = r_p + 8'd2;
                    n_k  = 8'd0;
                    n_st = r_added ? B_KPA : B_OUT;
                end else begin
                    n_k  = r_k + 8'd1;
                    n_st = B_CMA;
                end
            end
            B_NXT: begin
                if (r_i + TCW'(1) < r_cnt) begin
                    n_i  = r_i + TCW'(1);
                    n_st = B_RDT;
                end else begin
                    n_intail = 1'b1;
                    n_st     = B_TAIL;
                end
            end
            // append remaining suffixes at the end of the table
            B_TAIL: begin
                n_k = 8'd0;
                if (r_make && rem > MIN_LEN && room) begin
                    n_st = B_PUT;
                end else if (r_kind == REQ_QNAME) begin
                    n_st = r_added ? B_KPA : B_IDLE;
                end else begin
                    n_res.compressed     = 1'b0;
                    n_res.prefix_len     = 8'd0;
                    n_res.pointer_offset = 14'd0;
                    n_res.wr_len         = r_len;
                    n_st = r_added ? B_KPA : B_OUT;
                end
            end
            // copy the name into the store
            B_KPA: begin
                br_a = {r_bank, r_k};
                n_st = B_KPB;
            end
            B_KPB: begin
                sw_en = 1'b1;
                if ({1'b0, r_k} + 9'd1 == {1'b0, r_len}) begin
                    n_fill = r_fill + {{(SFW-8){1'b0}}, r_len};
                    n_st   = (r_kind == REQ_QNAME) ? B_IDLE : B_OUT;
                end else begin
                    n_k  = r_k + 8'd1;
                    n_st = B_KPA;
                end
            end
            B_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_st = B_IDLE;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= B_IDLE;
            r_cnt  <= '0;
            r_fill <= '0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_base <= n_base; r_len <= n_len; r_bank <= n_bank;
        r_p <= n_p; r_k <= n_k; r_i <= n_i; r_j <= n_j; r_make <= n_make;
        r_added <= n_added; r_intail <= n_intail; r_t <= n_t; r_res <= n_res;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= TCW'(MAX_TARGETS)) else $error("target count overflow");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SFW'(NAME_STORE_BYTES)) else $error("name store overflow");
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == B_PUT |-> room) else $error("insert into full table");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> r_st == B_IDLE) else $error("job taken while busy");

endmodule

[sv/dns_name_compressor_core.sv]
// dns_name_compressor_core: top level, front and back joined, result output register
// depends on dnc_pkg, dnc_front, dnc_back
//
//  channel | signals                           | beat
//  in      | i_in_valid, o_in_ready, i_in_data | one name byte
//  out     | o_out_valid, i_out_ready, o_out_data | one result per stored name
//
// bytes are taken one per cycle while the job queue has room; up to two
// finished names queue while the back works, which takes one step at a time:
// table entries visited, label steps, compared bytes, entries moved on insert and
// bytes copied to the store, over table and store memories of one read port each.
// reset is synchronous and clears counts, pointers and state only; no clearing pass.
module dns_name_compressor_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dnc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dnc_pkg::t_out o_out_data
);
    import dnc_pkg::*;

    t_bwr bwr;
    t_job job;
    logic job_valid, job_pop;
    logic res_valid, res_ready;
    t_out res;
    logic r_ov;
    t_out r_od;

    dnc_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_data,
        .o_bwr(bwr), .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    dnc_back u_back (
        .i_clk, .i_rst_n, .i_bwr(bwr), .i_job_valid(job_valid), .i_job(job),
        .o_job_pop(job_pop), .o_res_valid(res_valid), .i_res_ready(res_ready),
        .o_res(res)
    );

    // output register
    assign res_ready   = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ready) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_od <= res;
        end
    end

endmodule
